FILE: design/dmwc_pkg.sv
// Shared constants and types for the direct-mapped write-back cache.
package dmwc_pkg;

  localparam int LINE_BYTES_DEF = 8;
  localparam int NUM_LINES_DEF  = 32;
  localparam int ADDR_BITS_DEF  = 16;
  localparam int BYTE_W         = 8;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_t;

  // Requests from the sequencer to the tag store.
  typedef struct packed {
    logic fill;       // install the compare tag, valid and clean
    logic set_dirty;  // mark the indexed line dirty
  } tag_upd_t;

  // Lookup result of the tag store for the indexed line.
  typedef struct packed {
    logic hit;
    logic valid;
    logic dirty;
  } tag_stat_t;

endpackage

FILE: design/dmwc_ifc.sv
// Request and response channel interfaces of the cache.
interface dmwc_req_if #(
  parameter int ADDR_BITS = dmwc_pkg::ADDR_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [ADDR_BITS-1:0]         address;
  logic [dmwc_pkg::BYTE_W-1:0]  write_data;

  modport source(output valid, req_type, address, write_data, input ready);
  modport sink(input valid, req_type, address, write_data, output ready);
endinterface

interface dmwc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [dmwc_pkg::BYTE_W-1:0]  read_data;
  logic                         hit;
  logic                         dirty_before;

  modport source(output valid, read_data, hit, dirty_before, input ready);
  modport sink(input valid, read_data, hit, dirty_before, output ready);
endinterface

FILE: design/dmwc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module dmwc_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/dmwc_tags.sv
// Tag, valid and dirty store with the hit compare for the indexed line.
module dmwc_tags #(
  parameter int NUM_LINES = dmwc_pkg::NUM_LINES_DEF,
  parameter int TAG_W     = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(NUM_LINES)-1:0] idx,
  input  logic [TAG_W-1:0]             cmp_tag,
  input  dmwc_pkg::tag_upd_t           upd,
  output dmwc_pkg::tag_stat_t          stat,
  output logic [TAG_W-1:0]             vic_tag
);
  import dmwc_pkg::*;

  logic [TAG_W-1:0]     tag_r [NUM_LINES];
  logic [NUM_LINES-1:0] valid_r;
  logic [NUM_LINES-1:0] dirty_r;

  always_ff @(posedge clk) begin
    if (upd.fill) begin
      tag_r[idx] <= cmp_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (upd.fill) begin
        valid_r[idx] <= 1'b1;
        dirty_r[idx] <= 1'b0;
      end
      if (upd.set_dirty) begin
        dirty_r[idx] <= 1'b1;
      end
    end
  end

  assign vic_tag    = tag_r[idx];
  assign stat.valid = valid_r[idx];
  assign stat.dirty = dirty_r[idx];
  assign stat.hit   = valid_r[idx] && (tag_r[idx] == cmp_tag);

endmodule

FILE: design/direct_mapped_writeback_cache_unit.sv
// Top level of the direct-mapped write-back write-allocate byte cache.
//
//   channel   dir   handshake                 word contents
//   in_req    in    in_req.valid/ready        req_type, address, write_data
//   out_rsp   out   out_rsp.valid/ready       read_data, hit, dirty_before
//
// After reset the backing memory is cleared one byte per cycle; in_req is
// not ready meanwhile.
// An item then passes through accept, lookup and access on a hit; a miss
// first fills the line from the backing memory, and a dirty victim is
// written back before that fill.
// Each memory has byte-wide ports, and one copy counter serves both the
// write-back and the fill. A read adds a step to load the response register.
// A held response stalls only a later read at its last step.
module direct_mapped_writeback_cache_unit #(
  parameter int LINE_BYTES = dmwc_pkg::LINE_BYTES_DEF,
  parameter int NUM_LINES  = dmwc_pkg::NUM_LINES_DEF,
  parameter int ADDR_BITS  = dmwc_pkg::ADDR_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  dmwc_req_if.sink      in_req,
  dmwc_rsp_if.source    out_rsp
);
  import dmwc_pkg::*;

  // Address split. The tag is everything above the index; when the
  // address is too short to fill the tag, the upper bits read as zero.
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(NUM_LINES);
  localparam int TAG_RAW = ADDR_BITS - OFF_W - IDX_W;
  localparam int TAG_W  = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int EXT_W  = OFF_W + IDX_W + TAG_W;
  localparam int LINE_AW = IDX_W + OFF_W;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LOOKUP = 7'b0000100,
    ST_WB     = 7'b0001000,
    ST_FILL   = 7'b0010000,
    ST_ACCESS = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ADDR_BITS-1:0]   clr_cnt_r, clr_cnt_nxt;

  // Registered request.
  logic                   req_type_r;
  logic [ADDR_BITS-1:0]   addr_r;
  logic [BYTE_W-1:0]      wdata_r;

  // Lookup results kept for the response.
  logic                   hit_r, hit_nxt;
  logic                   dirty_before_r, dirty_before_nxt;

  // Copy counter shared by write-back and fill. cnt_r issues the read of
  // byte cnt_r; the write of that byte follows in the next cycle at cnt_d_r.
  logic [OFF_W:0]         cnt_r, cnt_nxt;
  logic [OFF_W-1:0]       cnt_d_r;
  logic                   pend_r, pend_nxt;
  logic                   issue;

  // Response register.
  logic                   out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]      out_data_r;
  logic                   out_hit_r;
  logic                   out_dirty_r;
  logic                   out_load;

  logic [EXT_W-1:0]       addr_ext;
  logic [TAG_W-1:0]       tag_cur;
  logic [IDX_W-1:0]       idx_cur;
  logic [OFF_W-1:0]       off_cur;
  logic [TAG_W-1:0]       vic_tag;
  logic [EXT_W-1:0]       vic_ext;
  logic [EXT_W-1:0]       fil_ext;

  tag_upd_t               tag_upd;
  tag_stat_t              tag_stat;

  logic                   mem_we, mem_re;
  logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]      mem_wdata, mem_rdata;

  logic                   line_we, line_re;
  logic [LINE_AW-1:0]     line_waddr, line_raddr;
  logic [BYTE_W-1:0]      line_wdata, line_rdata;

  assign addr_ext = EXT_W'(addr_r);
  assign tag_cur  = addr_ext[EXT_W-1 -: TAG_W];
  assign idx_cur  = addr_ext[OFF_W +: IDX_W];
  assign off_cur  = addr_ext[OFF_W-1:0];

  // Block addresses of the victim line and of the requested line.
  assign vic_ext  = {vic_tag, idx_cur, cnt_d_r};
  assign fil_ext  = {tag_cur, idx_cur, cnt_r[OFF_W-1:0]};

  assign issue    = !cnt_r[OFF_W];

  dmwc_tags #(
    .NUM_LINES (NUM_LINES),
    .TAG_W     (TAG_W)
  ) u_tags (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx     (idx_cur),
    .cmp_tag (tag_cur),
    .upd     (tag_upd),
    .stat    (tag_stat),
    .vic_tag (vic_tag)
  );

  dmwc_ram #(
    .DATA_W (BYTE_W),
    .ADDR_W (ADDR_BITS)
  ) u_backing (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dmwc_ram #(
    .DATA_W (BYTE_W),
    .ADDR_W (LINE_AW)
  ) u_lines (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    hit_nxt          = hit_r;
    dirty_before_nxt = dirty_before_r;
    cnt_nxt          = cnt_r;
    pend_nxt         = 1'b0;
    out_load         = 1'b0;
    tag_upd          = '0;
    mem_we           = 1'b0;
    mem_waddr        = vic_ext[ADDR_BITS-1:0];
    mem_wdata        = line_rdata;
    mem_re           = 1'b0;
    mem_raddr        = fil_ext[ADDR_BITS-1:0];
    line_we          = 1'b0;
    line_waddr       = {idx_cur, cnt_d_r};
    line_wdata       = mem_rdata;
    line_re          = 1'b0;
    line_raddr       = {idx_cur, cnt_r[OFF_W-1:0]};

    case (state_r)
      ST_CLEAR: begin
        // Zero the backing memory, one byte per cycle.
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        hit_nxt          = tag_stat.hit;
        dirty_before_nxt = tag_stat.dirty;
        cnt_nxt          = '0;
        if (tag_stat.hit) begin
          state_nxt = ST_ACCESS;
        end else if (tag_stat.valid && tag_stat.dirty) begin
          state_nxt = ST_WB;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_WB: begin
        // Line bytes out to the victim block.
        line_re  = issue;
        mem_we   = pend_r;
        pend_nxt = issue;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (!issue && pend_r) begin
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        // Requested block in from the backing memory.
        mem_re   = issue;
        line_we  = pend_r;
        pend_nxt = issue;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (!issue && pend_r) begin
          tag_upd.fill = 1'b1;
          cnt_nxt      = '0;
          pend_nxt     = 1'b0;
          state_nxt    = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (req_type_r == REQ_WRITE) begin
          line_we           = 1'b1;
          line_waddr        = {idx_cur, off_cur};
          line_wdata        = wdata_r;
          tag_upd.set_dirty = 1'b1;
          state_nxt         = ST_IDLE;
        end else begin
          line_re    = 1'b1;
          line_raddr = {idx_cur, off_cur};
          state_nxt  = ST_RESP;
        end
      end
      ST_RESP: begin
        // The line read data holds until the response register is free.
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_type_r <= in_req.req_type;
      addr_r     <= in_req.address;
      wdata_r    <= in_req.write_data;
    end
    hit_r          <= hit_nxt;
    dirty_before_r <= dirty_before_nxt;
    cnt_d_r        <= cnt_r[OFF_W-1:0];
    if (out_load) begin
      out_data_r  <= line_rdata;
      out_hit_r   <= hit_r;
      out_dirty_r <= dirty_before_r;
    end
  end

  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.read_data    = out_data_r;
  assign out_rsp.hit          = out_hit_r;
  assign out_rsp.dirty_before = out_dirty_r;

  // A response is only ever raised by the response step.
  a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("response raised outside the response step");

  // Writes never give a response.
  a_no_write_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(req_type_r) == REQ_READ))
    else $error("response raised for a write");

  // The byte access always finds its line resident.
  a_access_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCESS) |-> tag_stat.hit)
    else $error("access step without a resident line");

  // A fill only starts on a line that needs no write-back.
  a_fill_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) && (state_nxt == ST_FILL)
      |-> !(tag_stat.valid && tag_stat.dirty))
    else $error("fill would overwrite a dirty line");

endmodule
